### rtl/note_echo_generator_core_defines.svh
// Assertion macros for the note echo core
`ifndef NOTE_ECHO_GENERATOR_CORE_DEFINES_SVH
`define NOTE_ECHO_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define NEG_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NEG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define NEG_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define NEG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/neg_pkg.sv
`timescale 1ns / 1ps
package neg_pkg;
	localparam int MAX_REPEATS = 16;
	localparam int PITCH_COUNT = 128;
	localparam int PITCH_W = $clog2(PITCH_COUNT);
	localparam int MASK_W = MAX_REPEATS;
	localparam int BIT_W = $clog2(MASK_W);
	localparam int IDX_W = $clog2(MAX_REPEATS + 1);

	localparam logic [1:0] KIND_ON = 2'd0;
	localparam logic [1:0] KIND_OFF = 2'd1;

	localparam logic [2:0] REG_COUNT = 3'd0;
	localparam logic [2:0] REG_INTERVAL = 3'd1;
	localparam logic [2:0] REG_DECAY = 3'd2;
	localparam logic [2:0] REG_STEP = 3'd3;
	localparam logic [2:0] REG_PASS = 3'd4;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [6:0] pitch;
		logic [6:0] velocity;
		logic [31:0] duration;
		logic [47:0] time_stamp;
	} in_req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [6:0] out_pitch;
		logic [6:0] out_velocity;
		logic [31:0] out_duration;
		logic [47:0] out_time;
		logic last_of_run;
	} out_req_t;

	// classified request handed from front to back
	typedef struct packed {
		in_req_t req;
		logic fwd;
		logic is_on;
		logic echo;
		logic [IDX_W-1:0] reps;
		logic [16:0] decay;
		logic [5:0] step;
		logic [25:0] interval;
		logic [MASK_W-1:0] mask;
	} job_t;

	typedef struct packed {
		logic we;
		logic [PITCH_W-1:0] pitch;
		logic [MASK_W-1:0] mask;
		logic [5:0] step;
		logic [25:0] interval;
	} rec_t;
endpackage

### rtl/note_echo_generator_core.sv
`timescale 1ns / 1ps
// Note echo core.
// Input channel in_valid/in_ready/in_data carries note events; output
// channel out_valid/out_ready/out_data carries the original (note-on/off only if
// pass_original) followed by the echo copies, last_of_run on the final one.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while
// idle; the user must keep to this, as the block itself does not enforce it.
// A front part looks up the per-pitch held table (lookup register, then job
// register) and hands a classified request to the back sequencer, which
// walks the repeat loop one step per cycle while the output is not stalled,
// with one 24x17 multiply for the decay.
// Each result is held back one step so that the last one can be marked.
// The repeat steps are up to repeat_count (at most 16) for a note-on, 16
// for a note-off with a record, 0 otherwise. The back sequencer takes no
// new item until it has returned to idle after its run, and sets the
// throughput. A held note-on blocks the front until its record is stored.
// Reset clears the registers to their defaults and all held records.
// When the receiver stalls, the back sequencer holds its current result
// and the front stops accepting once its request is waiting.
`include "note_echo_generator_core_defines.svh"
module note_echo_generator_core import neg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_req_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [25:0] cfg_data
);
	logic [4:0] count_q;
	logic [25:0] interval_q;
	logic [16:0] decay_q;
	logic [5:0] step_q;
	logic pass_q;
	logic job_valid, job_ready;
	job_t job;
	rec_t rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd3;
			interval_q <= 26'd250000;
			decay_q <= 17'd39322;
			step_q <= 6'd0;
			pass_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT: count_q <= cfg_data[4:0];
				REG_INTERVAL: interval_q <= cfg_data;
				REG_DECAY: decay_q <= cfg_data[16:0];
				REG_STEP: step_q <= cfg_data[5:0];
				REG_PASS: pass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	neg_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.repeat_count(count_q), .repeat_interval(interval_q),
		.decay_factor(decay_q), .pitch_step(step_q), .pass_original(pass_q),
		.rec, .job_valid, .job_ready, .job
	);

	neg_back u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .rec,
		.out_valid, .out_ready, .out_data
	);

	`NEG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped under stall")
	`NEG_ASSERT_IMPL(a_rec_idle, clk, arst_n, rec.we |-> !job_valid || job_ready, "record while busy")
endmodule

### rtl/neg_front.sv
`timescale 1ns / 1ps
module neg_front import neg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_req_t in_data,
	input  logic [4:0] repeat_count,
	input  logic [25:0] repeat_interval,
	input  logic [16:0] decay_factor,
	input  logic [5:0] pitch_step,
	input  logic pass_original,
	input  rec_t rec,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);
	logic [PITCH_COUNT-1:0] valid_q;
	logic [MASK_W-1:0] mask_mem [PITCH_COUNT];
	logic [5:0] step_mem [PITCH_COUNT];
	logic [25:0] iv_mem [PITCH_COUNT];
	logic busy_q;
	logic lookup_s1;
	in_req_t req_s1;
	logic hit_s1;
	logic [MASK_W-1:0] mask_s1;
	logic [5:0] step_s1;
	logic [25:0] iv_s1;
	logic [PITCH_W-1:0] slot;
	logic rec_pending_q;

	assign slot = in_data.pitch[PITCH_W-1:0];
	// hold off while a held record from the back is still outstanding
	assign in_ready = !busy_q && !lookup_s1 && !rec_pending_q;

	always_ff @(posedge clk) begin
		if (rec.we) begin
			mask_mem[rec.pitch] <= rec.mask;
			step_mem[rec.pitch] <= rec.step;
			iv_mem[rec.pitch] <= rec.interval;
		end
		if (in_valid && in_ready) begin
			mask_s1 <= mask_mem[slot];
			step_s1 <= step_mem[slot];
			iv_s1 <= iv_mem[slot];
			req_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			busy_q <= 1'b0;
			lookup_s1 <= 1'b0;
			hit_s1 <= 1'b0;
			rec_pending_q <= 1'b0;
			job_valid <= 1'b0;
			job <= '0;
		end else begin
			if (rec.we) begin
				valid_q[rec.pitch] <= 1'b1;
				rec_pending_q <= 1'b0;
			end
			if (job_valid && job_ready) begin
				job_valid <= 1'b0;
				busy_q <= 1'b0;
			end
			lookup_s1 <= 1'b0;
			if (in_valid && in_ready) begin
				lookup_s1 <= 1'b1;
				busy_q <= 1'b1;
				hit_s1 <= valid_q[slot];
				if (in_data.event_kind == KIND_OFF)
					valid_q[slot] <= 1'b0;
				if (in_data.event_kind == KIND_ON && in_data.duration == '0)
					rec_pending_q <= 1'b1;
			end
			if (lookup_s1) begin
				job_valid <= 1'b1;
				job.req <= req_s1;
				job.is_on <= req_s1.event_kind == KIND_ON;
				job.fwd <= (req_s1.event_kind == KIND_ON || req_s1.event_kind == KIND_OFF)
					? pass_original : 1'b1;
				job.echo <= (req_s1.event_kind == KIND_ON)
					|| (req_s1.event_kind == KIND_OFF && hit_s1);
				job.reps <= (repeat_count > 5'(MAX_REPEATS)) ? IDX_W'(MAX_REPEATS)
					: IDX_W'(repeat_count);
				job.decay <= (decay_factor > 17'd65536) ? 17'd65536 : decay_factor;
				if (req_s1.event_kind == KIND_OFF) begin
					job.step <= step_s1;
					job.interval <= iv_s1;
					job.mask <= mask_s1;
				end else begin
					job.step <= pitch_step;
					job.interval <= repeat_interval;
					job.mask <= '1;
				end
			end
		end
	end
endmodule

### rtl/neg_back.sv
`timescale 1ns / 1ps
module neg_back import neg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output rec_t rec,
	output logic out_valid,
	input  logic out_ready,
	output out_req_t out_data
);
	typedef enum logic [1:0] {S_IDLE, S_FWD, S_ECHO, S_DONE} state_t;
	state_t state_q;
	job_t job_q;
	logic [IDX_W-1:0] i_q;
	logic [23:0] run_q;
	logic [6:0] vel_q;
	logic [47:0] t_q;
	logic signed [11:0] np_q;
	logic [MASK_W-1:0] got_q;
	out_req_t pend_q;
	logic pend_v_q;

	logic [40:0] prod;
	logic [23:0] run_n;
	logic [7:0] v_n;
	logic signed [11:0] np_n;
	logic [47:0] t_n;
	logic [BIT_W-1:0] bit_i;
	logic last_i;
	logic go, kill, skip;
	logic can_out;

	assign can_out = !out_valid || out_ready;
	assign prod = 41'(run_q) * 41'(job_q.decay) + 41'h8000;
	assign run_n = prod[39:16];
	assign v_n = 8'((25'(run_n) + 25'h8000) >> 16);
	assign np_n = np_q + 12'(signed'(job_q.step));
	assign t_n = t_q + 48'(job_q.interval);
	assign bit_i = BIT_W'(i_q - IDX_W'(1));
	assign last_i = (i_q == IDX_W'(MAX_REPEATS)) || (job_q.is_on && i_q == job_q.reps);
	assign kill = job_q.is_on && v_n == 8'd0;
	assign skip = np_n < 0 || np_n > 12'sd127 || !job_q.mask[bit_i];
	assign go = !kill && !skip;
	assign job_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			rec <= '0;
			out_data <= '0;
			job_q <= '0;
			i_q <= '0;
			run_q <= '0;
			vel_q <= '0;
			t_q <= '0;
			np_q <= '0;
			got_q <= '0;
			pend_q <= '0;
			pend_v_q <= 1'b0;
		end else begin
			rec.we <= 1'b0;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (job_valid) begin
					job_q <= job;
					run_q <= {job.req.velocity, 16'd0};
					vel_q <= job.req.velocity;
					t_q <= job.req.time_stamp;
					np_q <= 12'(job.req.pitch);
					i_q <= IDX_W'(1);
					got_q <= '0;
					state_q <= S_FWD;
				end
				S_FWD: if (can_out) begin
					if (job_q.fwd) begin
						pend_q <= {job_q.req.event_kind, job_q.req.pitch,
							job_q.req.velocity, job_q.req.duration,
							job_q.req.time_stamp, 1'b0};
						pend_v_q <= 1'b1;
					end
					state_q <= (job_q.echo && !(job_q.is_on && job_q.reps == '0))
						? S_ECHO : S_DONE;
				end
				S_ECHO: if (can_out) begin
					run_q <= run_n;
					np_q <= np_n;
					t_q <= t_n;
					i_q <= i_q + 1'b1;
					if (go) begin
						if (pend_v_q) begin
							out_valid <= 1'b1;
							out_data <= pend_q;
						end
						pend_q <= {job_q.req.event_kind, np_n[6:0],
							job_q.is_on ? v_n[6:0] : vel_q, job_q.req.duration,
							t_n, 1'b0};
						pend_v_q <= 1'b1;
						got_q[bit_i] <= 1'b1;
					end
					if (kill || last_i)
						state_q <= S_DONE;
				end
				S_DONE: if (can_out) begin
					// release the held request as the last of the run
					if (pend_v_q) begin
						out_valid <= 1'b1;
						out_data <= {pend_q[$bits(out_req_t)-1:1], 1'b1};
						pend_v_q <= 1'b0;
					end
					if (job_q.is_on && job_q.req.duration == '0) begin
						rec.we <= 1'b1;
						rec.pitch <= job_q.req.pitch[PITCH_W-1:0];
						rec.mask <= got_q;
						rec.step <= job_q.step;
						rec.interval <= job_q.interval;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
